FILE: rtl/core/pps_pkg.sv
package pps_pkg;

   localparam logic [16:0] US_PER_TENTH = 17'd100000;
   localparam logic [4:0]  MAX_FIRES    = 5'd16;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_TICK   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } pps_op_type;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_REJECTED = 3'd1,
      ST_FULL     = 3'd2,
      ST_FIRED    = 3'd3,
      ST_DONE     = 3'd4
   } pps_status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_SHIFT  = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_ROTATE = 2'd3
   } pps_cell_op_type;

   typedef struct packed {
      logic [47:0] deadline;
      logic [31:0] poll_id;
      logic [7:0]  poll_conn;
      logic [15:0] interval;
   } pps_entry_type;

   typedef struct packed {
      pps_cell_op_type kind;
      logic            keep;
      pps_entry_type   key;
   } pps_cmd_type;

endpackage

FILE: rtl/core/periodic_poll_scheduler.sv
// Channel   Ports                                     Handshake
// request   req_op, req_now_us, req_entry_id,         start high while busy low
//           req_connection, req_poll_interval,
//           req_inner_is_poll
// result    rsp_status, rsp_fired_id,                 rsp_strobe, one cycle each
//           rsp_fired_connection, rsp_removed_count,
//           rsp_last
//
// An add leaves busy low; its result appears on the following cycle.
// For each entry fired, a tick steps through head check with the interval multiply,
// saturating deadline sum, and sorted insertion into the cell row.
// A removal or clear rotates the row through its head, visiting each queued entry once.
// Reset empties the queue at once; entry contents are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module periodic_poll_scheduler import pps_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [47:0] req_now_us,
   input  logic [31:0] req_entry_id,
   input  logic [7:0]  req_connection,
   input  logic [15:0] req_poll_interval,
   input  logic        req_inner_is_poll,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_fired_id,
   output logic [7:0]  rsp_fired_connection,
   output logic [4:0]  rsp_removed_count,
   output logic        rsp_last
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_TICK_HEAD = 5'b00010,
      S_TICK_SUM  = 5'b00100,
      S_TICK_INS  = 5'b01000,
      S_SCAN      = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [4:0]       budget_ff, budget_in;
   logic             pending_ff, pending_in;
   logic [OCC_W-1:0] scan_left_ff, scan_left_in;
   logic [OCC_W-1:0] count_ff, count_in;
   logic             out_strobe_ff, out_strobe_in;

   logic [47:0]      now_ff, now_in;
   logic [31:0]      key_id_ff, key_id_in;
   logic [7:0]       key_conn_ff, key_conn_in;
   logic             is_clear_ff, is_clear_in;
   logic [31:0]      fire_id_ff, fire_id_in;
   logic [7:0]       fire_conn_ff, fire_conn_in;
   logic [15:0]      fire_iv_ff, fire_iv_in;
   logic [32:0]      product_ff, product_in;
   logic [47:0]      next_ff, next_in;
   pps_status_type   out_status_ff, out_status_in;
   logic [31:0]      out_id_ff, out_id_in;
   logic [7:0]       out_conn_ff, out_conn_in;
   logic [4:0]       out_count_ff, out_count_in;
   logic             out_last_ff, out_last_in;

   pps_cmd_type      cmd;
   pps_entry_type    cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_le;
   pps_entry_type    head;
   logic             due;
   logic             head_hit;
   logic [48:0]      sum;
   logic [OCC_W+4:0] occ_wide;
   logic [OCC_W+4:0] count_wide;
   logic [OCC_W+4:0] count_next_wide;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         pps_entry_type left_entry;
         logic          left_le;
         pps_entry_type right_entry;
         if (gi == 0) begin : g_first
            assign left_entry = cmd.key;
            assign left_le    = 1'b1;
         end else begin : g_inner
            assign left_entry = cell_entry[gi-1];
            assign left_le    = cell_le[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[gi];
         end else begin : g_body
            assign right_entry = cell_entry[gi+1];
         end
         pps_cell #(
            .INDEX (gi),
            .OCC_W (OCC_W)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .occ         (occ_ff),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (cell_entry[gi]),
            .le          (cell_le[gi])
         );
      end
   endgenerate

   assign head       = cell_entry[0];
   assign due        = (budget_ff != 5'd0) && (occ_ff != '0) && (head.deadline <= now_ff);
   assign head_hit   = is_clear_ff ? (head.poll_conn == key_conn_ff)
                                   : (head.poll_id == key_id_ff);
   assign sum        = {1'b0, now_ff} + {16'd0, product_ff};
   assign occ_wide   = {5'd0, occ_ff};
   assign count_wide = {5'd0, count_ff};

   assign busy                 = !state_ff[0];
   assign rsp_strobe           = out_strobe_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_fired_id         = out_id_ff;
   assign rsp_fired_connection = out_conn_ff;
   assign rsp_removed_count    = out_count_ff;
   assign rsp_last             = out_last_ff;

   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      budget_in       = budget_ff;
      pending_in      = pending_ff;
      scan_left_in    = scan_left_ff;
      count_in        = count_ff;
      now_in          = now_ff;
      key_id_in       = key_id_ff;
      key_conn_in     = key_conn_ff;
      is_clear_in     = is_clear_ff;
      fire_id_in      = fire_id_ff;
      fire_conn_in    = fire_conn_ff;
      fire_iv_in      = fire_iv_ff;
      product_in      = product_ff;
      next_in         = next_ff;
      out_strobe_in   = 1'b0;
      out_status_in   = out_status_ff;
      out_id_in       = out_id_ff;
      out_conn_in     = out_conn_ff;
      out_count_in    = out_count_ff;
      out_last_in     = out_last_ff;
      cmd.kind        = CELL_HOLD;
      cmd.keep        = 1'b0;
      cmd.key         = '{deadline: next_ff, poll_id: fire_id_ff,
                          poll_conn: fire_conn_ff, interval: fire_iv_ff};
      count_next_wide = count_wide + 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               now_in       = req_now_us;
               key_id_in    = req_entry_id;
               key_conn_in  = req_connection;
               out_id_in    = '0;
               out_conn_in  = '0;
               out_count_in = '0;
               out_last_in  = 1'b1;
               case (pps_op_type'(req_op))
                  OP_ADD: begin
                     out_strobe_in = 1'b1;
                     if ((req_poll_interval == 16'd0) || req_inner_is_poll) begin
                        out_status_in = ST_REJECTED;
                     end else if (occ_ff == OCC_FULL) begin
                        out_status_in = ST_FULL;
                     end else begin
                        cmd.kind      = CELL_INSERT;
                        cmd.key       = '{deadline: req_now_us, poll_id: req_entry_id,
                                          poll_conn: req_connection,
                                          interval: req_poll_interval};
                        occ_in        = occ_ff + 1'b1;
                        out_status_in = ST_ADDED;
                     end
                  end
                  OP_TICK: begin
                     budget_in  = (occ_wide < {{OCC_W{1'b0}}, MAX_FIRES}) ?
                                  occ_wide[4:0] : MAX_FIRES;
                     pending_in = 1'b0;
                     state_in   = S_TICK_HEAD;
                  end
                  default: begin
                     is_clear_in  = (pps_op_type'(req_op) == OP_CLEAR);
                     count_in     = '0;
                     scan_left_in = occ_ff;
                     if (occ_ff == '0) begin
                        out_strobe_in = 1'b1;
                        out_status_in = ST_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_TICK_HEAD: begin
            if (pending_ff) begin
               out_strobe_in = 1'b1;
               out_status_in = ST_FIRED;
               out_id_in     = fire_id_ff;
               out_conn_in   = fire_conn_ff;
               out_count_in  = '0;
               out_last_in   = !due;
            end else if (!due) begin
               out_strobe_in = 1'b1;
               out_status_in = ST_DONE;
               out_id_in     = '0;
               out_conn_in   = '0;
               out_count_in  = '0;
               out_last_in   = 1'b1;
            end
            if (due) begin
               cmd.kind     = CELL_SHIFT;
               occ_in       = occ_ff - 1'b1;
               fire_id_in   = head.poll_id;
               fire_conn_in = head.poll_conn;
               fire_iv_in   = head.interval;
               product_in   = 33'(head.interval) * 33'(US_PER_TENTH);
               state_in     = S_TICK_SUM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TICK_SUM: begin
            next_in  = sum[48] ? {48{1'b1}} : sum[47:0];
            state_in = S_TICK_INS;
         end
         S_TICK_INS: begin
            cmd.kind   = CELL_INSERT;
            occ_in     = occ_ff + 1'b1;
            budget_in  = budget_ff - 1'b1;
            pending_in = 1'b1;
            state_in   = S_TICK_HEAD;
         end
         S_SCAN: begin
            cmd.kind = CELL_ROTATE;
            cmd.keep = !head_hit;
            cmd.key  = head;
            if (head_hit) begin
               occ_in   = occ_ff - 1'b1;
               count_in = count_ff + 1'b1;
            end else begin
               count_next_wide = count_wide;
            end
            scan_left_in = scan_left_ff - 1'b1;
            if (scan_left_ff == OCC_W'(1)) begin
               out_strobe_in = 1'b1;
               out_status_in = ST_DONE;
               out_id_in     = '0;
               out_conn_in   = '0;
               out_count_in  = (count_next_wide > (OCC_W + 5)'(31)) ?
                               5'd31 : count_next_wide[4:0];
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         budget_ff     <= '0;
         pending_ff    <= 1'b0;
         scan_left_ff  <= '0;
         count_ff      <= '0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         budget_ff     <= budget_in;
         pending_ff    <= pending_in;
         scan_left_ff  <= scan_left_in;
         count_ff      <= count_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      key_id_ff     <= key_id_in;
      key_conn_ff   <= key_conn_in;
      is_clear_ff   <= is_clear_in;
      fire_id_ff    <= fire_id_in;
      fire_conn_ff  <= fire_conn_in;
      fire_iv_ff    <= fire_iv_in;
      product_ff    <= product_in;
      next_ff       <= next_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_conn_ff   <= out_conn_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

endmodule

FILE: rtl/core/pps_cell.sv
module pps_cell import pps_pkg::*; #(
   parameter int INDEX = 0,
   parameter int OCC_W = 5
) (
   input  logic               clock,
   input  pps_cmd_type        cmd,
   input  logic [OCC_W-1:0]   occ,
   input  pps_entry_type      left_entry,
   input  logic               left_le,
   input  pps_entry_type      right_entry,
   output pps_entry_type      entry,
   output logic               le
);

   localparam logic [OCC_W-1:0] IDX      = OCC_W'(INDEX);
   localparam logic [OCC_W-1:0] IDX_NEXT = OCC_W'(INDEX + 1);

   pps_entry_type entry_ff;
   pps_entry_type entry_in;

   // A cell is ordered before the new entry when it is occupied and not later.
   assign le    = (IDX < occ) && (entry_ff.deadline <= cmd.key.deadline);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         CELL_INSERT: begin
            if (!le) begin
               entry_in = left_le ? cmd.key : left_entry;
            end
         end
         CELL_ROTATE: begin
            entry_in = (cmd.keep && (IDX_NEXT == occ)) ? cmd.key : right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
